// ===== hdl/mzhfd_pkg.sv =====
`timescale 1ns / 1ps

package mzhfd_pkg;

  // Fixed field widths of the block.
  localparam int TEMP_W      = 8;   // one temperature sample
  localparam int SMOOTH_W    = 11;  // smoothed value, AVG_LEN times the average
  localparam int CMP_W       = 12;  // compare width: smoothed value plus scaled tolerance
  localparam int CNT_LIM_W   = 5;   // count_limit register
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int NUM_INPUTS  = 5;   // zones that have a sample port
  localparam int MASK_W      = 5;   // zones reported in trip_mask

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_TOLERANCE  = 2'd2;

  // Configuration reset values.
  localparam logic [TEMP_W-1:0]    FIXED_THRESHOLD_RST = 8'd57;
  localparam logic [CNT_LIM_W-1:0] COUNT_LIMIT_RST     = 5'd26;
  localparam logic [TEMP_W-1:0]    RISE_TOLERANCE_RST  = 8'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SWRITE,
    ST_SCAN,
    ST_SLAST,
    ST_DONE
  } state_t;

  // Per-cycle strobes from the sequencer to every lane.
  typedef struct packed {
    logic raw_we;      // write the new sample into the raw ring
    logic raw_re;      // read the raw ring at rd_addr
    logic raw_ok;      // the raw entry being read has been written since reset
    logic acc_clr;     // clear the smoothing accumulator
    logic smooth_we;   // write the finished sum into the smoothed ring
    logic scan_re;     // read the smoothed ring at rd_addr
    logic scan_ok;     // the smoothed entry being read has been written since reset
    logic scan_first;  // first read of the scan, the reference slot
    logic fixed_on;    // fixed-temperature test runs on this transaction
    logic rise_on;     // rate-of-rise test runs on this transaction
  } lane_ctl_t;

  // Thresholds already scaled to the smoothed format.
  typedef struct packed {
    logic [CMP_W-1:0]     hot_limit;
    logic [CMP_W-1:0]     rise_step;
    logic [CNT_LIM_W-1:0] count_limit;
  } lane_cfg_t;

endpackage

// ===== hdl/mzhfd_lane.sv =====
`timescale 1ns / 1ps

// One zone: raw and smoothed rings, the smoothing accumulator and the scan logic.
module mzhfd_lane #(
  parameter int WINDOW = 30
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mzhfd_pkg::TEMP_W-1:0]     sample,
  input  mzhfd_pkg::lane_ctl_t             ctl,
  input  mzhfd_pkg::lane_cfg_t             cfg,
  input  logic [$clog2(WINDOW)-1:0]        slot,
  input  logic [$clog2(WINDOW)-1:0]        rd_addr,
  output logic                             trip
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int HC_W  = (CNT_W > mzhfd_pkg::CNT_LIM_W) ? CNT_W : mzhfd_pkg::CNT_LIM_W;

  logic [mzhfd_pkg::TEMP_W-1:0]   raw_mem    [WINDOW];
  logic [mzhfd_pkg::SMOOTH_W-1:0] smooth_mem [WINDOW];

  logic [mzhfd_pkg::TEMP_W-1:0]   raw_q;
  logic [mzhfd_pkg::SMOOTH_W-1:0] sm_q;
  logic                           acc_go_q;
  logic                           raw_ok_q;
  logic                           eval_q;
  logic                           sm_ok_q;
  logic                           first_q;

  logic [mzhfd_pkg::SMOOTH_W-1:0] acc;
  logic [mzhfd_pkg::SMOOTH_W-1:0] acc_next;
  logic [mzhfd_pkg::CMP_W-1:0]    ref_val;
  logic [mzhfd_pkg::CMP_W-1:0]    ref_sel;
  logic [mzhfd_pkg::CMP_W-1:0]    need;
  logic [mzhfd_pkg::CMP_W-1:0]    smooth_val;
  logic [HC_W-1:0]                hot_cnt;
  logic                           rise_hit;
  logic                           hot;
  logic                           rise;

  always_ff @(posedge clk) begin
    if (ctl.raw_we) begin
      raw_mem[slot] <= sample;
    end
    if (ctl.raw_re) begin
      raw_q <= raw_mem[rd_addr];
    end
    if (ctl.smooth_we) begin
      smooth_mem[slot] <= acc_next;
    end
    if (ctl.scan_re) begin
      sm_q <= smooth_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_go_q <= 1'b0;
      raw_ok_q <= 1'b0;
      eval_q   <= 1'b0;
      sm_ok_q  <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      acc_go_q <= ctl.raw_re;
      raw_ok_q <= ctl.raw_ok;
      eval_q   <= ctl.scan_re;
      sm_ok_q  <= ctl.scan_ok;
      first_q  <= ctl.scan_first;
    end
  end

  // Entries never written since reset read as zero.
  always_comb begin
    acc_next = acc;
    if (acc_go_q && raw_ok_q) begin
      acc_next = acc + mzhfd_pkg::SMOOTH_W'(raw_q);
    end
  end

  assign smooth_val = sm_ok_q ? mzhfd_pkg::CMP_W'(sm_q) : '0;
  assign ref_sel    = first_q ? smooth_val : ref_val;
  assign need       = ref_sel + cfg.rise_step;
  assign hot        = (smooth_val > cfg.hot_limit);
  assign rise       = (smooth_val >= need);

  always_ff @(posedge clk) begin
    if (ctl.acc_clr) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
    if (eval_q) begin
      if (first_q) begin
        ref_val  <= smooth_val;
        hot_cnt  <= HC_W'(hot);
        rise_hit <= rise;
      end else begin
        hot_cnt  <= hot_cnt + HC_W'(hot);
        rise_hit <= rise_hit | rise;
      end
    end
  end

  assign trip = (ctl.fixed_on && (hot_cnt > HC_W'(cfg.count_limit))) ||
                (ctl.rise_on && rise_hit);

endmodule

// ===== hdl/mzhfd_ctrl.sv =====
`timescale 1ns / 1ps

// Sequencer shared by all lanes: ring position, warm-up, entry valid bits and the
// per-transaction pass through sum, smoothed write and window scan.
module mzhfd_ctrl #(
  parameter int WINDOW  = 30,
  parameter int AVG_LEN = 5
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        load_ok,
  output logic                        done,
  output mzhfd_pkg::lane_ctl_t        ctl,
  output logic [$clog2(WINDOW)-1:0]   slot,
  output logic [$clog2(WINDOW)-1:0]   rd_addr
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int WARM_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;

  mzhfd_pkg::state_t state;
  mzhfd_pkg::state_t state_next;

  logic [SLOT_W-1:0] ring_slot;
  logic [SLOT_W-1:0] sum_addr;
  logic [SLOT_W-1:0] scan_addr;
  logic [SLOT_W-1:0] step;
  logic [WARM_W-1:0] warmup_count;
  logic [WINDOW-1:0] raw_valid;
  logic [WINDOW-1:0] smooth_valid;
  logic              fixed_on;
  logic              rise_on;
  logic              accept;
  logic              smoothing;
  logic              sum_last;
  logic              scan_last;

  assign accept    = in_valid && !in_stall;
  assign smoothing = (warmup_count >= WARM_W'(AVG_LEN - 1));
  assign sum_last  = (step == SLOT_W'(AVG_LEN - 1));
  assign scan_last = (step == SLOT_W'(WINDOW - 1));
  // The scan reads the reference slot first, then slots zero upward.
  assign scan_addr = (step == '0) ? SLOT_W'(WINDOW - 1) : step - SLOT_W'(1);
  assign slot      = ring_slot;

  always_comb begin
    state_next = state;
    unique case (state)
      mzhfd_pkg::ST_IDLE: begin
        if (accept) begin
          if (smoothing) begin
            state_next = mzhfd_pkg::ST_SUM;
          end else if (ring_slot == '0) begin
            state_next = mzhfd_pkg::ST_SCAN;
          end else begin
            state_next = mzhfd_pkg::ST_DONE;
          end
        end
      end
      mzhfd_pkg::ST_SUM: begin
        if (sum_last) begin
          state_next = mzhfd_pkg::ST_SWRITE;
        end
      end
      mzhfd_pkg::ST_SWRITE: begin
        state_next = mzhfd_pkg::ST_SCAN;
      end
      mzhfd_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = mzhfd_pkg::ST_SLAST;
        end
      end
      mzhfd_pkg::ST_SLAST: begin
        state_next = mzhfd_pkg::ST_DONE;
      end
      mzhfd_pkg::ST_DONE: begin
        if (load_ok) begin
          state_next = mzhfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mzhfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    done           = 1'b0;
    rd_addr        = sum_addr;
    ctl            = '0;
    ctl.fixed_on   = fixed_on;
    ctl.rise_on    = rise_on;
    unique case (state)
      mzhfd_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        ctl.raw_we  = accept;
        ctl.acc_clr = accept;
      end
      mzhfd_pkg::ST_SUM: begin
        ctl.raw_re = 1'b1;
        ctl.raw_ok = raw_valid[sum_addr];
      end
      mzhfd_pkg::ST_SWRITE: begin
        ctl.smooth_we = 1'b1;
      end
      mzhfd_pkg::ST_SCAN: begin
        rd_addr        = scan_addr;
        ctl.scan_re    = 1'b1;
        ctl.scan_ok    = smooth_valid[scan_addr];
        ctl.scan_first = (step == '0);
      end
      mzhfd_pkg::ST_SLAST: begin
      end
      mzhfd_pkg::ST_DONE: begin
        done = load_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mzhfd_pkg::ST_IDLE;
      ring_slot    <= '0;
      sum_addr     <= '0;
      step         <= '0;
      warmup_count <= '0;
      raw_valid    <= '0;
      smooth_valid <= '0;
      fixed_on     <= 1'b0;
      rise_on      <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        mzhfd_pkg::ST_IDLE: begin
          if (accept) begin
            raw_valid[ring_slot] <= 1'b1;
            sum_addr             <= ring_slot;
            step                 <= '0;
            fixed_on             <= smoothing;
            rise_on              <= (ring_slot == '0);
            if (!smoothing) begin
              warmup_count <= warmup_count + WARM_W'(1);
            end
          end
        end
        mzhfd_pkg::ST_SUM: begin
          sum_addr <= (sum_addr == '0) ? SLOT_W'(WINDOW - 1) : sum_addr - SLOT_W'(1);
          step     <= sum_last ? '0 : step + SLOT_W'(1);
        end
        mzhfd_pkg::ST_SWRITE: begin
          smooth_valid[ring_slot] <= 1'b1;
          step                    <= '0;
        end
        mzhfd_pkg::ST_SCAN: begin
          step <= step + SLOT_W'(1);
        end
        mzhfd_pkg::ST_SLAST: begin
          step <= '0;
        end
        mzhfd_pkg::ST_DONE: begin
          if (load_ok) begin
            ring_slot <= (ring_slot == SLOT_W'(WINDOW - 1)) ? '0 : ring_slot + SLOT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/mzhfd_merge.sv =====
`timescale 1ns / 1ps

// Combines the lane trips into the mask, latches the alarm and holds the result.
module mzhfd_merge #(
  parameter int ZONES = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          done,
  input  logic [ZONES-1:0]              trips,
  input  logic                          out_stall,
  output logic                          load_ok,
  output logic                          out_valid,
  output logic                          alarm,
  output logic [mzhfd_pkg::MASK_W-1:0]  trip_mask
);

  logic                         alarm_latched;
  logic                         any_trip;
  logic [mzhfd_pkg::MASK_W-1:0] mask_now;

  assign any_trip = |trips;
  assign load_ok  = !out_valid || !out_stall;

  for (genvar i = 0; i < mzhfd_pkg::MASK_W; i++) begin : g_mask
    if (i < ZONES) begin : g_zone
      assign mask_now[i] = trips[i];
    end else begin : g_none
      assign mask_now[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      alarm_latched <= 1'b0;
    end else begin
      if (done) begin
        out_valid     <= 1'b1;
        alarm_latched <= alarm_latched | any_trip;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      alarm     <= alarm_latched | any_trip;
      trip_mask <= mask_now;
    end
  end

endmodule

// ===== hdl/multi_zone_heat_fire_detector_core.sv =====
`timescale 1ns / 1ps
// Sequence: once smoothing has started, a transaction passes through the sum, smoothed-write
//   and scan states before its result is offered; during warm-up it goes straight to the
//   result, or through the scan when the ring is at slot zero. The next input can be taken in
//   the same cycle that the result is offered. Inputs are taken only while idle; each pass is
//   serial, set by the single read port of each lane's raw and smoothed rings.
// Reset (rst, synchronous, active high) clears all sample history, the ring position, warm-up
//   and the alarm, and restores the configuration registers to their defaults.

// Multi-zone heat fire detector.
//
// Every input transaction carries one sample per zone. Each zone has its own lane that keeps
// a WINDOW-deep raw ring and a WINDOW-deep smoothed ring. The lanes run in lockstep under one
// sequencer:
//   1. On accept, each lane writes its sample into the raw ring at the current slot.
//   2. Once warm-up is over, the lanes read the last AVG_LEN raw entries one per cycle, walking
//      backward around the ring, add them up and write the sum into the smoothed ring.
//   3. The lanes then scan the whole smoothed ring, one entry per cycle. The first entry read
//      is the last slot of the window, which is the reference for the rate-of-rise test. Each
//      entry is counted as hot against the scaled fixed threshold and compared against the
//      reference plus the scaled rise tolerance.
//   4. A merge stage collects the per-zone trips into the mask, latches the alarm and holds
//      the result in an output register until the downstream side takes it.
// Ring entries not yet written since reset read as zero through per-entry valid bits kept by
// the sequencer, so no clearing pass is needed after reset.
// Configuration writes are always accepted; they are expected only while the block is idle.
module multi_zone_heat_fire_detector_core #(
  parameter int ZONES   = 5,
  parameter int WINDOW  = 30,
  parameter int AVG_LEN = 5
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mzhfd_pkg::TEMP_W-1:0]      temp_zone0,
  input  logic [mzhfd_pkg::TEMP_W-1:0]      temp_zone1,
  input  logic [mzhfd_pkg::TEMP_W-1:0]      temp_zone2,
  input  logic [mzhfd_pkg::TEMP_W-1:0]      temp_zone3,
  input  logic [mzhfd_pkg::TEMP_W-1:0]      temp_zone4,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              alarm,
  output logic [mzhfd_pkg::MASK_W-1:0]      trip_mask,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mzhfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mzhfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = $clog2(WINDOW);

  // Configuration registers.
  logic [mzhfd_pkg::TEMP_W-1:0]    fixed_threshold;
  logic [mzhfd_pkg::CNT_LIM_W-1:0] count_limit;
  logic [mzhfd_pkg::TEMP_W-1:0]    rise_tolerance;

  mzhfd_pkg::lane_ctl_t ctl;
  mzhfd_pkg::lane_cfg_t lane_cfg;

  logic [SLOT_W-1:0]            slot;
  logic [SLOT_W-1:0]            rd_addr;
  logic [ZONES-1:0]             trips;
  logic                         done;
  logic                         load_ok;
  logic [mzhfd_pkg::TEMP_W-1:0] samples [mzhfd_pkg::NUM_INPUTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_threshold <= mzhfd_pkg::FIXED_THRESHOLD_RST;
      count_limit     <= mzhfd_pkg::COUNT_LIMIT_RST;
      rise_tolerance  <= mzhfd_pkg::RISE_TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mzhfd_pkg::CFG_FIXED_THRESHOLD: begin
          fixed_threshold <= cfg_data;
        end
        mzhfd_pkg::CFG_COUNT_LIMIT: begin
          count_limit <= cfg_data[mzhfd_pkg::CNT_LIM_W-1:0];
        end
        mzhfd_pkg::CFG_RISE_TOLERANCE: begin
          rise_tolerance <= cfg_data;
        end
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  // Thresholds are compared in the smoothed format, which is AVG_LEN times the average.
  assign lane_cfg.hot_limit   = mzhfd_pkg::CMP_W'(fixed_threshold) *
                                mzhfd_pkg::CMP_W'(AVG_LEN);
  assign lane_cfg.rise_step   = mzhfd_pkg::CMP_W'(rise_tolerance) *
                                mzhfd_pkg::CMP_W'(AVG_LEN);
  assign lane_cfg.count_limit = count_limit;

  assign samples[0] = temp_zone0;
  assign samples[1] = temp_zone1;
  assign samples[2] = temp_zone2;
  assign samples[3] = temp_zone3;
  assign samples[4] = temp_zone4;

  mzhfd_ctrl #(
    .WINDOW  (WINDOW),
    .AVG_LEN (AVG_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .load_ok  (load_ok),
    .done     (done),
    .ctl      (ctl),
    .slot     (slot),
    .rd_addr  (rd_addr)
  );

  // One lane per zone. Zones without a sample port see a constant zero.
  for (genvar z = 0; z < ZONES; z++) begin : g_lane
    logic [mzhfd_pkg::TEMP_W-1:0] lane_sample;
    if (z < mzhfd_pkg::NUM_INPUTS) begin : g_port
      assign lane_sample = samples[z];
    end else begin : g_zero
      assign lane_sample = '0;
    end

    mzhfd_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .sample  (lane_sample),
      .ctl     (ctl),
      .cfg     (lane_cfg),
      .slot    (slot),
      .rd_addr (rd_addr),
      .trip    (trips[z])
    );
  end

  mzhfd_merge #(
    .ZONES (ZONES)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .done      (done),
    .trips     (trips),
    .out_stall (out_stall),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .alarm     (alarm),
    .trip_mask (trip_mask)
  );

endmodule
